// ===== rtl/pmtp_pkg.sv =====
// Shared types, codes and byte tables for the plot-to-printer path translator.
`default_nettype none

package pmtp_pkg;

    // Input selector carried on tuser
    localparam logic [1:0] FUNC_INSTR = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;

    // Instruction opcodes
    localparam logic [15:0] OP_FRAME = 16'd1;
    localparam logic [15:0] OP_MOVE  = 16'd2;
    localparam logic [15:0] OP_DRAW  = 16'd3;
    localparam logic [15:0] OP_WIDTH = 16'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_LEFT   = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_BOTTOM = 3'd1;
    localparam logic [2:0] CFG_PLOT_WIDTH    = 3'd2;
    localparam logic [2:0] CFG_PLOT_HEIGHT   = 3'd3;
    localparam logic [2:0] CFG_PEN_BASE      = 3'd4;
    localparam logic [2:0] CFG_PEN_SLOPE     = 3'd5;

    // Printer language bytes
    localparam logic [7:0] BYTE_CREATE_PATH = 8'd230;
    localparam logic [7:0] BYTE_DRAW_PATH   = 8'd234;
    localparam logic [7:0] BYTE_LINE_STYLE  = 8'd15;
    localparam logic [7:0] BYTE_END_PAGE    = 8'd219;
    localparam logic [7:0] BYTE_END_JOB     = 8'd255;
    localparam logic [7:0] BYTE_FRAME_A     = 8'd135;
    localparam logic [7:0] BYTE_FRAME_B     = 8'd137;
    localparam logic [7:0] BYTE_DOC_A       = 8'd205;
    localparam logic [7:0] BYTE_DOC_B       = 8'd125;
    localparam logic [7:0] BYTE_SET_PEN     = 8'd232;

    localparam logic [15:0] FULL_SCALE = 16'd32767;

    localparam int WORD_BYTES = 4;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_START = 3'd1,
        KIND_END   = 3'd2,
        KIND_FRAME = 3'd3,
        KIND_MOVE  = 3'd4,
        KIND_DRAW  = 3'd5,
        KIND_WIDTH = 3'd6,
        KIND_BAD   = 3'd7
    } kind_t;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MULY  = 9'b000000010,
        ST_PLAN  = 9'b000000100,
        ST_HEAD  = 9'b000001000,
        ST_POINT = 9'b000010000,
        ST_TRAIL = 9'b000100000,
        ST_TAIL  = 9'b001000000,
        ST_POST  = 9'b010000000,
        ST_FLAG  = 9'b100000000
    } state_t;

    // Number of bytes that follow the path for each kind of item
    function automatic logic [2:0] tail_len(input kind_t kind);
        logic [2:0] len;
        case (kind)
            KIND_START: len = 3'd4;
            KIND_END:   len = 3'd2;
            KIND_FRAME: len = 3'd7;
            KIND_WIDTH: len = 3'd2;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] tail_byte(input kind_t kind, input logic [2:0] idx,
                                             input logic [7:0] pen_base,
                                             input logic [7:0] pen_byte);
        logic [7:0] b;
        b = 8'd0;
        case (kind)
            KIND_START:
            begin
                case (idx)
                    3'd0:    b = BYTE_DOC_A;
                    3'd1:    b = BYTE_DOC_B;
                    3'd2:    b = BYTE_SET_PEN;
                    default: b = pen_base;
                endcase
            end
            KIND_END:
            begin
                b = (idx == 3'd0) ? BYTE_END_PAGE : BYTE_END_JOB;
            end
            KIND_FRAME:
            begin
                case (idx)
                    3'd0:    b = BYTE_END_PAGE;
                    3'd1:    b = BYTE_FRAME_A;
                    3'd4:    b = BYTE_FRAME_B;
                    default: b = 8'd0;
                endcase
            end
            KIND_WIDTH:
            begin
                b = (idx == 3'd0) ? BYTE_SET_PEN : pen_byte;
            end
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/plot_metacode_to_printer_path_top.sv =====
// Plot instruction to printer path translator: point store, byte sequencer and word packer.
`default_nettype none

// Takes plot instructions and document markers on the input stream and emits printer
// path-language bytes packed into words of up to four bytes (first byte in bits 31..24).
// Points of the open path live in a single-port-write, registered-read point store of
// MAX_POINTS entries. A draw that only appends a point passes accept, y multiply, then scale
// and store; a move that emits nothing then writes its point to open a new path. Start,
// end, frame and set-width items pass accept and plan before their bytes; a move or a draw
// that emits a path passes accept, y multiply and plan before its bytes. The sequencer emits
// one byte per cycle while the output is not stalled, and a path flush of n points adds
// 5 + 4n bytes, paced by the point store read port delivering one point per four bytes. An
// unknown opcode yields one flag word. A stalled output word holds the sequencer once the
// next word is complete; a new input word is taken as soon as the sequencer is idle.
module plot_metacode_to_printer_path_top #(
    parameter int MAX_POINTS = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // opcode[15:0], x_coord[30:16], y_coord[45:31], zero[47:46]
    input  wire  [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // out_data[31:0], out_bytes[34:32], zero[39:35]
    output logic        m_tuser,   // bad_opcode[0]
    output logic        m_tlast,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [15:0] cfg_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    // Configuration
    logic [15:0] origin_left_reg;
    logic [15:0] origin_bottom_reg;
    logic [15:0] plot_width_reg;
    logic [15:0] plot_height_reg;
    logic [7:0]  pen_base_reg;
    logic [7:0]  pen_slope_reg;

    // Control
    pmtp_pkg::state_t state_reg, state_next;
    pmtp_pkg::kind_t  kind_reg, kind_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] flush_n_reg, flush_n_next;
    logic [AW-1:0] point_idx_reg, point_idx_next;
    logic [2:0]    byte_idx_reg, byte_idx_next;
    logic          post_reg, post_next;

    // Payload
    logic [14:0] x_reg, x_next;
    logic [14:0] y_reg, y_next;
    logic [30:0] prod_reg, prod_next;
    logic [15:0] xs_reg, xs_next;
    logic [31:0] pt_reg, pt_next;
    logic [7:0]  pen_reg, pen_next;

    // Packer and output register
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  acc_cnt_reg, acc_cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic [2:0]  out_bytes_reg, out_bytes_next;
    logic        out_bad_reg, out_bad_next;
    logic        out_last_reg, out_last_next;

    // Point store
    logic [31:0]   point_mem [MAX_POINTS];
    logic [31:0]   rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // Byte sequencer
    logic        gen_valid;
    logic [7:0]  gen_byte;
    logic        gen_last;
    logic        word_done;
    logic        out_free;
    logic        fire;
    logic [2:0]  cur_tail_len;
    logic [15:0] cnt_word;
    logic [31:0] placed;
    logic [15:0] ys;
    logic        accept;
    pmtp_pkg::kind_t in_kind;

    // origin + floor(prod / 32767), saturated; 32767 = 2^15 - 1 so fold the high part twice
    function automatic logic [15:0] scale_coord(input logic [30:0] prod,
                                                input logic [15:0] origin);
        logic [15:0] q0;
        logic [16:0] r;
        logic [16:0] q1;
        logic [15:0] r2;
        logic [16:0] q;
        logic [17:0] sum;
        q0  = prod[30:15];
        r   = {2'b00, prod[14:0]} + {1'b0, q0};
        q1  = {1'b0, q0} + {15'b0, r[16:15]};
        r2  = {1'b0, r[14:0]} + {14'b0, r[16:15]};
        q   = (r2 >= pmtp_pkg::FULL_SCALE) ? q1 + 17'd1 : q1;
        sum = {2'b00, origin} + {1'b0, q};
        return (sum > 18'd65535) ? 16'hFFFF : sum[15:0];
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == pmtp_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    assign cur_tail_len = pmtp_pkg::tail_len(kind_reg);
    assign cnt_word     = 16'(flush_n_reg);
    assign ys           = scale_coord(prod_reg, origin_bottom_reg);

    always_comb
    begin
        in_kind = pmtp_pkg::KIND_NONE;
        unique case (s_tuser)
            pmtp_pkg::FUNC_START: in_kind = pmtp_pkg::KIND_START;
            pmtp_pkg::FUNC_END:   in_kind = pmtp_pkg::KIND_END;
            pmtp_pkg::FUNC_INSTR:
            begin
                unique case (s_tdata[15:0])
                    pmtp_pkg::OP_FRAME: in_kind = pmtp_pkg::KIND_FRAME;
                    pmtp_pkg::OP_MOVE:  in_kind = pmtp_pkg::KIND_MOVE;
                    pmtp_pkg::OP_DRAW:  in_kind = pmtp_pkg::KIND_DRAW;
                    pmtp_pkg::OP_WIDTH: in_kind = pmtp_pkg::KIND_WIDTH;
                    default:            in_kind = pmtp_pkg::KIND_BAD;
                endcase
            end
            default: in_kind = pmtp_pkg::KIND_NONE;
        endcase
    end

    // Current byte of the stream
    always_comb
    begin
        gen_valid = 1'b0;
        gen_byte  = 8'd0;
        gen_last  = 1'b0;
        unique case (state_reg)
            pmtp_pkg::ST_HEAD:
            begin
                gen_valid = 1'b1;
                case (byte_idx_reg)
                    3'd0:    gen_byte = pmtp_pkg::BYTE_CREATE_PATH;
                    3'd1:    gen_byte = cnt_word[15:8];
                    default: gen_byte = cnt_word[7:0];
                endcase
            end
            pmtp_pkg::ST_POINT:
            begin
                gen_valid = 1'b1;
                case (byte_idx_reg)
                    3'd0:    gen_byte = rd_data_reg[31:24];
                    3'd1:    gen_byte = rd_data_reg[23:16];
                    3'd2:    gen_byte = rd_data_reg[15:8];
                    default: gen_byte = rd_data_reg[7:0];
                endcase
            end
            pmtp_pkg::ST_TRAIL:
            begin
                gen_valid = 1'b1;
                gen_byte  = (byte_idx_reg == 3'd0) ? pmtp_pkg::BYTE_DRAW_PATH
                                                   : pmtp_pkg::BYTE_LINE_STYLE;
                gen_last  = (byte_idx_reg != 3'd0) && (cur_tail_len == 3'd0);
            end
            pmtp_pkg::ST_TAIL:
            begin
                gen_valid = 1'b1;
                gen_byte  = pmtp_pkg::tail_byte(kind_reg, byte_idx_reg, pen_base_reg, pen_reg);
                gen_last  = (byte_idx_reg == cur_tail_len - 3'd1);
            end
            default:
            begin
                gen_valid = 1'b0;
            end
        endcase
    end

    assign word_done = (acc_cnt_reg == 2'd3) || gen_last;
    assign fire      = gen_valid && (!word_done || out_free);
    assign placed    = {gen_byte, 24'h000000} >> {acc_cnt_reg, 3'b000};

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        count_next      = count_reg;
        flush_n_next    = flush_n_reg;
        point_idx_next  = point_idx_reg;
        byte_idx_next   = byte_idx_reg;
        post_next       = post_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        prod_next       = prod_reg;
        xs_next         = xs_reg;
        pt_next         = pt_reg;
        pen_next        = pen_reg;
        acc_next        = acc_reg;
        acc_cnt_next    = acc_cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_bytes_next  = out_bytes_reg;
        out_bad_next    = out_bad_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        mem_wdata       = {xs_reg, ys};
        mem_re          = 1'b0;
        mem_raddr       = '0;

        // Pack the current byte; hand a finished word to the output register
        if (fire)
        begin
            if (word_done)
            begin
                out_valid_next = 1'b1;
                out_data_next  = acc_reg | placed;
                out_bytes_next = {1'b0, acc_cnt_reg} + 3'd1;
                out_bad_next   = 1'b0;
                out_last_next  = gen_last;
                acc_next       = '0;
                acc_cnt_next   = 2'd0;
            end
            else
            begin
                acc_next     = acc_reg | placed;
                acc_cnt_next = acc_cnt_reg + 2'd1;
            end
        end

        unique case (state_reg)
            pmtp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next = in_kind;
                    x_next    = s_tdata[30:16];
                    y_next    = s_tdata[45:31];
                    prod_next = 31'(32'(s_tdata[30:16]) * 32'(plot_width_reg));
                    unique case (in_kind) inside
                        pmtp_pkg::KIND_NONE: state_next = pmtp_pkg::ST_IDLE;
                        pmtp_pkg::KIND_BAD:  state_next = pmtp_pkg::ST_FLAG;
                        pmtp_pkg::KIND_MOVE, pmtp_pkg::KIND_DRAW:
                                             state_next = pmtp_pkg::ST_MULY;
                        default:             state_next = pmtp_pkg::ST_PLAN;
                    endcase
                end
            end
            pmtp_pkg::ST_MULY:
            begin
                xs_next    = scale_coord(prod_reg, origin_left_reg);
                prod_next  = 31'(32'(y_reg) * 32'(plot_height_reg));
                state_next = pmtp_pkg::ST_PLAN;
            end
            pmtp_pkg::ST_PLAN:
            begin
                pt_next       = {xs_reg, ys};
                pen_next      = pen_base_reg + 8'((x_reg[7:0] - 8'd1) * pen_slope_reg);
                post_next     = 1'b0;
                flush_n_next  = count_reg;
                byte_idx_next = 3'd0;
                unique case (kind_reg) inside
                    pmtp_pkg::KIND_START:
                    begin
                        count_next = '0;
                        state_next = pmtp_pkg::ST_TAIL;
                    end
                    pmtp_pkg::KIND_END, pmtp_pkg::KIND_FRAME:
                    begin
                        count_next = '0;
                        state_next = (count_reg >= CW'(2)) ? pmtp_pkg::ST_HEAD
                                                           : pmtp_pkg::ST_TAIL;
                    end
                    pmtp_pkg::KIND_WIDTH:
                    begin
                        if (count_reg >= CW'(2))
                        begin
                            count_next = '0;
                            state_next = pmtp_pkg::ST_HEAD;
                        end
                        else
                        begin
                            state_next = pmtp_pkg::ST_TAIL;
                        end
                    end
                    pmtp_pkg::KIND_MOVE:
                    begin
                        post_next  = 1'b1;
                        state_next = (count_reg >= CW'(2)) ? pmtp_pkg::ST_HEAD
                                                           : pmtp_pkg::ST_POST;
                    end
                    pmtp_pkg::KIND_DRAW:
                    begin
                        mem_we = 1'b1;
                        if (count_reg == CW'(MAX_POINTS - 1))
                        begin
                            // Store full: emit all points, then reopen with this point
                            flush_n_next = CW'(MAX_POINTS);
                            post_next    = 1'b1;
                            state_next   = pmtp_pkg::ST_HEAD;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                            state_next = pmtp_pkg::ST_IDLE;
                        end
                    end
                    default: state_next = pmtp_pkg::ST_IDLE;
                endcase
            end
            pmtp_pkg::ST_HEAD:
            begin
                if (fire)
                begin
                    if (byte_idx_reg == 3'd2)
                    begin
                        mem_re         = 1'b1;
                        mem_raddr      = '0;
                        point_idx_next = '0;
                        byte_idx_next  = 3'd0;
                        state_next     = pmtp_pkg::ST_POINT;
                    end
                    else
                    begin
                        byte_idx_next = byte_idx_reg + 3'd1;
                    end
                end
            end
            pmtp_pkg::ST_POINT:
            begin
                if (fire)
                begin
                    if (byte_idx_reg == 3'd3)
                    begin
                        byte_idx_next = 3'd0;
                        if (CW'(point_idx_reg) == flush_n_reg - CW'(1))
                        begin
                            state_next = pmtp_pkg::ST_TRAIL;
                        end
                        else
                        begin
                            // Fetch the next point while its first byte is due next cycle
                            mem_re         = 1'b1;
                            mem_raddr      = point_idx_reg + AW'(1);
                            point_idx_next = point_idx_reg + AW'(1);
                        end
                    end
                    else
                    begin
                        byte_idx_next = byte_idx_reg + 3'd1;
                    end
                end
            end
            pmtp_pkg::ST_TRAIL:
            begin
                if (fire)
                begin
                    if (byte_idx_reg != 3'd0)
                    begin
                        byte_idx_next = 3'd0;
                        if (cur_tail_len != 3'd0)
                            state_next = pmtp_pkg::ST_TAIL;
                        else if (post_reg)
                            state_next = pmtp_pkg::ST_POST;
                        else
                            state_next = pmtp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        byte_idx_next = 3'd1;
                    end
                end
            end
            pmtp_pkg::ST_TAIL:
            begin
                if (fire)
                begin
                    if (gen_last)
                    begin
                        byte_idx_next = 3'd0;
                        state_next    = post_reg ? pmtp_pkg::ST_POST : pmtp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        byte_idx_next = byte_idx_reg + 3'd1;
                    end
                end
            end
            pmtp_pkg::ST_POST:
            begin
                // Reopen the path with the pending point, once any read-out of the store is done
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = pt_reg;
                count_next = CW'(1);
                post_next  = 1'b0;
                state_next = pmtp_pkg::ST_IDLE;
            end
            pmtp_pkg::ST_FLAG:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_bytes_next = 3'd0;
                    out_bad_next   = 1'b1;
                    out_last_next  = 1'b1;
                    state_next     = pmtp_pkg::ST_IDLE;
                end
            end
            default: state_next = pmtp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            point_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= point_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_left_reg   <= 16'd85;
            origin_bottom_reg <= 16'd50;
            plot_width_reg    <= 16'd2490;
            plot_height_reg   <= 16'd1905;
            pen_base_reg      <= 8'd2;
            pen_slope_reg     <= 8'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pmtp_pkg::CFG_ORIGIN_LEFT:   origin_left_reg   <= cfg_data;
                pmtp_pkg::CFG_ORIGIN_BOTTOM: origin_bottom_reg <= cfg_data;
                pmtp_pkg::CFG_PLOT_WIDTH:    plot_width_reg    <= cfg_data;
                pmtp_pkg::CFG_PLOT_HEIGHT:   plot_height_reg   <= cfg_data;
                pmtp_pkg::CFG_PEN_BASE:      pen_base_reg      <= cfg_data[7:0];
                pmtp_pkg::CFG_PEN_SLOPE:     pen_slope_reg     <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pmtp_pkg::ST_IDLE;
            kind_reg      <= pmtp_pkg::KIND_NONE;
            count_reg     <= '0;
            flush_n_reg   <= '0;
            point_idx_reg <= '0;
            byte_idx_reg  <= 3'd0;
            post_reg      <= 1'b0;
            acc_reg       <= '0;
            acc_cnt_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            count_reg     <= count_next;
            flush_n_reg   <= flush_n_next;
            point_idx_reg <= point_idx_next;
            byte_idx_reg  <= byte_idx_next;
            post_reg      <= post_next;
            acc_reg       <= acc_next;
            acc_cnt_reg   <= acc_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        prod_reg      <= prod_next;
        xs_reg        <= xs_next;
        pt_reg        <= pt_next;
        pen_reg       <= pen_next;
        out_data_reg  <= out_data_next;
        out_bytes_reg <= out_bytes_next;
        out_bad_reg   <= out_bad_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_bytes_reg, out_data_reg};
    assign m_tuser  = out_bad_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/pmtp_checker.sv =====
// Port-level checks on the output stream of the path translator, bound to the top level.
`default_nettype none

module pmtp_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata,
    input wire        m_tuser,
    input wire        m_tlast
);

    // A stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output word changed while stalled");

    // A flag word is alone, empty and closes its item
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata[34:32] == 3'd0)
                                && (m_tdata[31:0] == 32'd0))
        else $error("flag word malformed");

    // Every word but the final one of an item is full
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tdata[34:32] == 3'(pmtp_pkg::WORD_BYTES)) && !m_tuser)
        else $error("short word before end of item");

    // A data word carries one to four bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[34:32] != 3'd0)
                                 && (m_tdata[34:32] <= 3'(pmtp_pkg::WORD_BYTES)))
        else $error("data word byte count out of range");

endmodule

bind plot_metacode_to_printer_path_top pmtp_checker u_pmtp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
